// ----- design/frur_pkg.sv -----
`default_nettype none
package frur_pkg;

  localparam int unsigned OneQ16 = 65536;

  // Register index at which each stage of the main pipeline holds its item.
  localparam int unsigned SqrtSteps = 17;
  localparam int unsigned DivSteps  = 16;
  localparam int unsigned PosA = 0;
  localparam int unsigned PosB = PosA + SqrtSteps + 1;
  localparam int unsigned PosTir = PosB + 1;
  localparam int unsigned PosD = PosB + DivSteps + 1;
  localparam int unsigned PosE = PosD + SqrtSteps + 1;
  localparam int unsigned PosF = PosE + 1;
  localparam int unsigned PosFlag = PosF + 1;
  localparam int unsigned PosG = PosF + DivSteps + 1;
  localparam int unsigned PosH = PosG + 1;
  localparam int unsigned Depth = PosH + 1;

  typedef struct packed {
    logic signed [17:0] cos_incident;
    logic [15:0]        index_incident;
    logic [15:0]        index_transmitted;
  } in_t;

  typedef struct packed {
    logic [16:0] reflectance;
    logic        total_internal;
  } out_t;

  // Per-item side data that rides along the arithmetic units.
  typedef struct packed {
    logic [16:0] ci;
    logic [15:0] ni;
    logic [15:0] nt;
    logic        tir;
    logic        zero_den;
    logic        eq_s;
    logic        eq_p;
  } side_t;

endpackage
`default_nettype wire

// ----- design/frur_sqrt.sv -----
`default_nettype none
module frur_sqrt import frur_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [33:0] radicand,
  output logic [16:0]      root
);

  // One result bit per stage, restoring digit recurrence.
  logic [18:0] rem   [SqrtSteps];
  logic [16:0] rt    [SqrtSteps];
  logic [33:0] rest  [SqrtSteps];
  logic [18:0] rem_next  [SqrtSteps];
  logic [16:0] rt_next   [SqrtSteps];
  logic [33:0] rest_next [SqrtSteps];

  always_comb begin
    logic [18:0] r_in;
    logic [16:0] q_in;
    logic [33:0] v_in;
    logic [20:0] r2;
    logic [20:0] t;
    for (int k = 0; k < SqrtSteps; k++) begin
      r_in = (k == 0) ? 19'd0 : rem[(k == 0) ? 0 : k - 1];
      q_in = (k == 0) ? 17'd0 : rt[(k == 0) ? 0 : k - 1];
      v_in = (k == 0) ? radicand : rest[(k == 0) ? 0 : k - 1];
      r2 = {r_in, v_in[33:32]};
      t  = {2'b00, q_in, 2'b01};
      if (r2 >= t) begin
        rem_next[k] = 19'(r2 - t);
        rt_next[k]  = {q_in[15:0], 1'b1};
      end else begin
        rem_next[k] = r2[18:0];
        rt_next[k]  = {q_in[15:0], 1'b0};
      end
      rest_next[k] = {v_in[31:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SqrtSteps; k++) begin
        rem[k]  <= rem_next[k];
        rt[k]   <= rt_next[k];
        rest[k] <= rest_next[k];
      end
    end
  end

  assign root = rt[SqrtSteps-1];

endmodule
`default_nettype wire

// ----- design/frur_div.sv -----
`default_nettype none
module frur_div import frur_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [33:0] rem_init,
  input  wire logic [15:0] low_bits,
  input  wire logic [33:0] divisor,
  output logic [15:0]      quotient
);

  // Restoring division, one quotient bit per stage; rem_init must be below divisor.
  logic [33:0] rem  [DivSteps];
  logic [15:0] low  [DivSteps];
  logic [33:0] dvs  [DivSteps];
  logic [15:0] quo  [DivSteps];
  logic [33:0] rem_next [DivSteps];
  logic [15:0] low_next [DivSteps];
  logic [15:0] quo_next [DivSteps];

  always_comb begin
    logic [33:0] r_in;
    logic [15:0] l_in;
    logic [33:0] d_in;
    logic [15:0] q_in;
    logic [34:0] t;
    for (int k = 0; k < DivSteps; k++) begin
      r_in = (k == 0) ? rem_init : rem[(k == 0) ? 0 : k - 1];
      l_in = (k == 0) ? low_bits : low[(k == 0) ? 0 : k - 1];
      d_in = (k == 0) ? divisor  : dvs[(k == 0) ? 0 : k - 1];
      q_in = (k == 0) ? 16'd0    : quo[(k == 0) ? 0 : k - 1];
      t = {r_in, l_in[15]};
      if (t >= {1'b0, d_in}) begin
        rem_next[k] = 34'(t - {1'b0, d_in});
        quo_next[k] = {q_in[14:0], 1'b1};
      end else begin
        rem_next[k] = t[33:0];
        quo_next[k] = {q_in[14:0], 1'b0};
      end
      low_next[k] = {l_in[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DivSteps; k++) begin
        rem[k] <= rem_next[k];
        low[k] <= low_next[k];
        quo[k] <= quo_next[k];
        dvs[k] <= (k == 0) ? divisor : dvs[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign quotient = quo[DivSteps-1];

endmodule
`default_nettype wire

// ----- design/fresnel_unpolarised_reflectance.sv -----
`default_nettype none
// Unpolarized Fresnel reflectance, fully pipelined.
// Throughput: one beat per cycle while the result is not stalled; the long paths are two 17-stage square roots and
// three 16-stage dividers, all pipelined one digit per stage.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
module fresnel_unpolarised_reflectance import frur_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire in_t  sample,
  input  wire logic sample_valid,
  output logic      sample_stall,
  output out_t      result,
  output logic      result_valid,
  input  wire logic result_stall
);

  // The pipeline advances whenever the output register is free or being taken.
  logic en;
  assign en = !(result_valid && result_stall);
  assign sample_stall = !en;

  logic  vld [Depth];
  side_t sb  [Depth];

  // Stage A: clamp the cosine and form 1 - ci^2.
  logic [16:0] ci_c;
  logic [33:0] v1;
  always_comb begin
    if (sample.cos_incident[17]) begin
      ci_c = 17'd0;
    end else if (sample.cos_incident > 18'sd65536) begin
      ci_c = 17'(OneQ16);
    end else begin
      ci_c = sample.cos_incident[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1 <= 34'h1_0000_0000 - ({17'd0, ci_c} * {17'd0, ci_c});
    end
  end

  // Incidence sine.
  logic [16:0] si;
  frur_sqrt u_sqrt_si (.clk, .en, .radicand(v1), .root(si));

  // Stage B: ni * si, then the Snell quotient; a quotient of one or more is
  // total internal reflection, which also covers a zero transmitted index.
  logic [32:0] num_b;
  always_ff @(posedge clk) begin
    if (en) begin
      num_b <= {1'b0, sb[PosB-1].ni} * {16'd0, si};
    end
  end

  logic tir_c;
  assign tir_c = num_b >= {1'b0, sb[PosB].nt, 16'd0};

  logic [15:0] st;
  frur_div u_div_st (
    .clk, .en,
    .rem_init({18'd0, num_b[31:16]}),
    .low_bits(num_b[15:0]),
    .divisor({18'd0, sb[PosB].nt}),
    .quotient(st)
  );

  // Stage D: 1 - st^2, then the transmitted cosine.
  logic [33:0] v2;
  always_ff @(posedge clk) begin
    if (en) begin
      v2 <= 34'h1_0000_0000 - {2'b00, {16'd0, st} * {16'd0, st}};
    end
  end

  logic [16:0] ct;
  frur_sqrt u_sqrt_ct (.clk, .en, .radicand(v2), .root(ct));

  // Stage E: the four index-cosine products.
  logic [32:0] pa, pb, pc, pd;
  always_ff @(posedge clk) begin
    if (en) begin
      pa <= {1'b0, sb[PosE-1].ni} * {16'd0, sb[PosE-1].ci};
      pb <= {1'b0, sb[PosE-1].nt} * {16'd0, ct};
      pc <= {1'b0, sb[PosE-1].ni} * {16'd0, ct};
      pd <= {1'b0, sb[PosE-1].nt} * {16'd0, sb[PosE-1].ci};
    end
  end

  // Stage F: denominators and difference magnitudes of both ratios.
  logic [33:0] den_s, den_p, mag_s, mag_p;
  always_ff @(posedge clk) begin
    if (en) begin
      den_s <= {1'b0, pa} + {1'b0, pb};
      den_p <= {1'b0, pc} + {1'b0, pd};
      mag_s <= (pa >= pb) ? {1'b0, pa - pb} : {1'b0, pb - pa};
      mag_p <= (pc >= pd) ? {1'b0, pc - pd} : {1'b0, pd - pc};
    end
  end

  // The magnitude never exceeds its denominator; equality means a ratio of one.
  logic zero_c, eq_s_c, eq_p_c;
  assign zero_c = (den_s == 34'd0) || (den_p == 34'd0);
  assign eq_s_c = mag_s == den_s;
  assign eq_p_c = mag_p == den_p;

  logic [15:0] qs, qp;
  frur_div u_div_rs (
    .clk, .en, .rem_init(mag_s), .low_bits(16'd0), .divisor(den_s), .quotient(qs)
  );
  frur_div u_div_rp (
    .clk, .en, .rem_init(mag_p), .low_bits(16'd0), .divisor(den_p), .quotient(qp)
  );

  // Stage G: square both ratios.
  logic [16:0] rs, rp;
  logic [33:0] sq_s, sq_p;
  assign rs = sb[PosG-1].eq_s ? 17'(OneQ16) : {1'b0, qs};
  assign rp = sb[PosG-1].eq_p ? 17'(OneQ16) : {1'b0, qp};
  always_ff @(posedge clk) begin
    if (en) begin
      sq_s <= rs * rs;
      sq_p <= rp * rp;
    end
  end

  // Stage H: average, round to nearest and pick the special cases.
  logic [34:0] sum_c;
  logic [17:0] refl_c;
  out_t        res_c;
  always_comb begin
    sum_c  = {1'b0, sq_s} + {1'b0, sq_p} + 35'd65536;
    refl_c = sum_c[34:17];
    res_c.total_internal = sb[PosG].tir;
    if (sb[PosG].tir || sb[PosG].zero_den || refl_c > 18'(OneQ16)) begin
      res_c.reflectance = 17'(OneQ16);
    end else begin
      res_c.reflectance = refl_c[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= res_c;
    end
  end

  // Side data entering the slots where a stage adds its flags.
  side_t at_tir, at_flag;
  always_comb begin
    at_tir           = sb[PosTir-1];
    at_tir.tir       = tir_c;
    at_flag          = sb[PosFlag-1];
    at_flag.zero_den = zero_c;
    at_flag.eq_s     = eq_s_c;
    at_flag.eq_p     = eq_p_c;
  end

  // Side data and valid bits move one place per advancing cycle; stages that
  // learn a flag write it into their own slot.
  always_ff @(posedge clk) begin
    if (en) begin
      sb[0].ci       <= ci_c;
      sb[0].ni       <= sample.index_incident;
      sb[0].nt       <= sample.index_transmitted;
      sb[0].tir      <= 1'b0;
      sb[0].zero_den <= 1'b0;
      sb[0].eq_s     <= 1'b0;
      sb[0].eq_p     <= 1'b0;
      for (int i = 1; i < Depth; i++) begin
        if (i == PosTir) begin
          sb[i] <= at_tir;
        end else if (i == PosFlag) begin
          sb[i] <= at_flag;
        end else begin
          sb[i] <= sb[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Depth; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= sample_valid;
      for (int i = 1; i < Depth; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  assign result_valid = vld[Depth-1];

  a_refl_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.reflectance <= 17'(OneQ16))
    else $error("reflectance above one");

  a_tir_full: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.total_internal) |-> result.reflectance == 17'(OneQ16))
    else $error("total internal reflection without full reflectance");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> sample_stall)
    else $error("input taken while pipeline frozen");

endmodule
`default_nettype wire

// ----- bench/fresnel_unpolarised_reflectance_check.sv -----
module fresnel_unpolarised_reflectance_check import frur_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  in_t         sample,
  input  logic        sample_valid,
  input  logic        sample_stall,
  input  out_t        result,
  input  logic        result_valid,
  input  logic        result_stall,
  output int unsigned errors,
  output int unsigned pending,
  output int unsigned results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  out_t reflectance_queue[$];

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] amp_ratio(logic [63:0] pos, logic [63:0] neg,
                                            logic [63:0] den);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (pos >= neg) ? pos - neg : neg - pos;
    q = (mag << 16) / den;
    return (q > OneQ16) ? 64'(OneQ16) : q;
  endfunction

  function automatic out_t predict_reflectance(in_t s);
    out_t o;
    logic [63:0] ci, si, st, ct, ni, nt, a, b, c, d, rs, rp, sum, refl;
    ni = 64'(s.index_incident);
    nt = 64'(s.index_transmitted);
    if (s.cos_incident < 0) ci = 0;
    else if (s.cos_incident > 18'sd65536) ci = OneQ16;
    else ci = 64'(s.cos_incident);
    si = isqrt((64'd1 << 32) - ci * ci);
    o.reflectance = 17'(OneQ16);
    o.total_internal = 1'b1;
    if (nt == 0) return o;
    st = (ni * si) / nt;
    if (st >= OneQ16) return o;
    o.total_internal = 1'b0;
    ct = isqrt((64'd1 << 32) - st * st);
    a = ni * ci;
    b = nt * ct;
    c = ni * ct;
    d = nt * ci;
    if (a + b == 0 || c + d == 0) return o;
    rs = amp_ratio(a, b, a + b);
    rp = amp_ratio(c, d, c + d);
    sum = rs * rs + rp * rp;
    refl = (sum + (64'd1 << 16)) >> 17;
    if (refl > OneQ16) refl = OneQ16;
    o.reflectance = refl[16:0];
    return o;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  assign pending = reflectance_queue.size();

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      errors = 0;
      results_seen <= 0;
      reflectance_queue.delete();
    end else begin
      if (sample_valid && !sample_stall)
        reflectance_queue.push_back(predict_reflectance(sample));
      if (result_valid && !result_stall) begin
        results_seen <= results_seen + 1;
        if (reflectance_queue.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = reflectance_queue.pop_front();
          if (result.reflectance !== want.reflectance)
            report_mismatch($sformatf("reflectance %0d, expected %0d",
                                      result.reflectance, want.reflectance));
          if (result.total_internal !== want.total_internal)
            report_mismatch($sformatf("total_internal %0b, expected %0b",
                                      result.total_internal, want.total_internal));
        end
      end
    end
  end
endmodule

// ----- bench/fresnel_unpolarised_reflectance_test.sv -----
module fresnel_unpolarised_reflectance_test;
  import frur_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBeats = 828;
  localparam int unsigned IdleLimit = 5000;

  logic clk;
  logic rst;
  in_t  sample;
  logic sample_valid;
  logic sample_stall;
  out_t result;
  logic result_valid;
  logic result_stall;

  int unsigned errors, pending, results_seen;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off;
  bit          stimulus_done;
  int unsigned directed_count;

  fresnel_unpolarised_reflectance dut (
    .clk, .rst, .sample, .sample_valid, .sample_stall,
    .result, .result_valid, .result_stall
  );

  fresnel_unpolarised_reflectance_check checker_inst (
    .clk, .rst, .sample, .sample_valid, .sample_stall,
    .result, .result_valid, .result_stall,
    .errors, .pending, .results_seen
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random at the current phase's rate. During the
  // long hold-off it stalls every cycle so the pipeline fills and pushes
  // back on the sender.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      result_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // The watchdog counts cycles with no accepted beat on either channel.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
        idle_cycles = 0;
      else if (!rst)
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no progress for %0d cycles", IdleLimit);
        $display("fresnel_unpolarised_reflectance_test NOT OK");
        $finish;
      end
    end
  end

  // Offers one beat and holds it until accepted. The sender may first idle
  // for a while, which lets gaps land on every pipeline phase.
  task automatic send_beat(in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample <= beat;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // Random beat. Mostly angles inside 0..1 and indices near typical optical
  // values, so both the reflecting and the total-internal cases come up
  // often; the rest is anything the fields allow.
  function automatic in_t random_beat();
    in_t b;
    int unsigned pick;
    pick = $urandom_range(9);
    b.cos_incident = (pick < 7) ? 18'($urandom_range(65536)) : 18'($urandom);
    if (pick < 6) begin
      b.index_incident = 16'($urandom_range(40000, 16384));
      b.index_transmitted = 16'($urandom_range(40000, 16384));
    end else begin
      b.index_incident = 16'($urandom);
      b.index_transmitted = 16'($urandom);
    end
    return b;
  endfunction

  task automatic send_directed(logic signed [17:0] ci, logic [15:0] ni, logic [15:0] nt);
    in_t b;
    b.cos_incident = ci;
    b.index_incident = ni;
    b.index_transmitted = nt;
    send_beat(b);
    directed_count++;
  endtask

  initial begin
    int unsigned phase;
    rst = 1'b1;
    sample = '0;
    sample_valid = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    stimulus_done = 1'b0;
    directed_count = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: normal incidence, grazing, clamping on both sides, the
    // extremes of both indices, a zero transmitted index, matched indices,
    // and a dense-to-thin pair that crosses into total internal reflection.
    send_directed(18'sd65536, 16'd16384, 16'd24576);
    send_directed(18'sd0, 16'd16384, 16'd24576);
    send_directed(-18'sd1, 16'd16384, 16'd24576);
    send_directed(-18'sd131072, 16'd16384, 16'd24576);
    send_directed(18'sd131071, 16'd16384, 16'd24576);
    send_directed(18'sd65537, 16'd24576, 16'd16384);
    send_directed(18'sd32768, 16'd24576, 16'd16384);
    send_directed(18'sd60000, 16'd24576, 16'd16384);
    send_directed(18'sd40000, 16'd24576, 16'd0);
    send_directed(18'sd40000, 16'd0, 16'd0);
    send_directed(18'sd40000, 16'd0, 16'd16384);
    send_directed(18'sd0, 16'd0, 16'd16384);
    send_directed(18'sd0, 16'd1, 16'd1);
    send_directed(18'sd65536, 16'd65535, 16'd65535);
    send_directed(18'sd65536, 16'd65535, 16'd1);
    send_directed(18'sd65536, 16'd1, 16'd65535);
    send_directed(18'sd1, 16'd65535, 16'd1);
    send_directed(18'sd1, 16'd1, 16'd65535);
    send_directed(18'sd30000, 16'd21845, 16'd21845);
    send_directed(18'sd43690, 16'hAAAA, 16'h5555);
    send_directed(18'sd21845, 16'h5555, 16'hAAAA);

    // Random part in four idling phases. In the first phase the receiver
    // also holds off for a long stretch while the sender keeps offering.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (int i = 0; i < RandomBeats / 4; i++) begin
        if (phase == 0 && i == 20) hold_off = 1'b1;
        if (phase == 0 && i == 120) hold_off = 1'b0;
        send_beat(random_beat());
      end
    end
    sample_valid <= 1'b0;
    recv_stall_pct = 0;
    stimulus_done = 1'b1;
  end

  // The long hold-off is timed in cycles here, so it ends even though the
  // sender is blocked by the full pipeline.
  initial begin
    int unsigned held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        held++;
        if (held >= 300) hold_off = 1'b0;
      end
    end
  end

  initial begin
    wait (stimulus_done);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d directed and %0d random beats, %0d results checked,",
             directed_count, RandomBeats, results_seen);
    $display("under four idle and stall mixes plus one long receiver hold-off.");
    if (errors == 0 && pending == 0)
      $display("fresnel_unpolarised_reflectance_test OK");
    else
      $display("fresnel_unpolarised_reflectance_test NOT OK");
    $finish;
  end
endmodule
